[design/i2crm_pkg.sv]
`timescale 1ns / 1ps

package i2crm_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_SDA_LOW   = 3'd1;
  localparam logic [2:0] STS_SDA_HIGH  = 3'd2;
  localparam logic [2:0] STS_NO_ACK    = 3'd3;
  localparam logic [2:0] STS_ZERO_CNT  = 3'd4;

  localparam logic [7:0] PHASE_TICKS_RST = 8'd5;
  localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

  localparam logic [1:0] STAGE_DEV  = 2'd0;
  localparam logic [1:0] STAGE_REG  = 2'd1;
  localparam logic [1:0] STAGE_LAST = 2'd2;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST0, PH_ST1, PH_ST2,
    PH_TX0, PH_TX1, PH_TX2,
    PH_WA0, PH_WA1, PH_WA2, PH_WA3,
    PH_RX0, PH_RX1,
    PH_AK0, PH_AK1, PH_AK2, PH_AK3,
    PH_SP0, PH_SP1, PH_SP2, PH_SP3
  } phase_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] device_address;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic [7:0] read_count;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic [7:0] read_byte;
    logic       byte_valid;
    logic       last_byte;
    logic       busy_res;
    logic       done_res;
    logic [2:0] status;
  } res_t;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] tick;
    logic [3:0] bit_cnt;
    logic [7:0] shift;
    logic [7:0] bytes_left;
    logic [7:0] held_device;
    logic [7:0] held_register;
    logic [7:0] held_data;
    logic       read_mode;
    logic [1:0] stage;
    logic [2:0] pending;
    logic       scl;
    logic       sda;
  } state_t;

endpackage

[design/i2crm_if.sv]
`timescale 1ns / 1ps

interface i2crm_cmd_if;
  logic             valid;
  logic             ready;
  i2crm_pkg::cmd_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2crm_res_if;
  logic             valid;
  logic             ready;
  i2crm_pkg::res_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface i2crm_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/i2c_register_master.sv]
`timescale 1ns / 1ps

// i2c register master, one tick item per transfer on cmd_i
// each cmd_i transfer advances the phase timer by one tick; command 1 starts
// a one-byte register write, command 2 a burst register read, both ignored
// while busy_res is set
// every cmd_i transfer yields exactly one res_o transfer carrying the scl/sda
// drives, any received byte with its last-byte mark, busy/done and status
// the result is registered and is offered on res_o in the cycle after the cmd_i transfer
// throughput: one item per cycle unless stalled, the whole tick step is a
// single pass of logic between the state registers and the result register
// cfg_i writes phase_ticks (ticks per line phase, 0 acts as 1);
// write only while no transaction runs
// reset: phase idle, counters cleared, both lines released, phase_ticks = 5
// stall: while res_o is held off, the result register keeps its item and
// cmd_i.ready drops; it returns in the cycle res_o.ready is seen

module i2c_register_master (
  input  logic                clk_i,
  input  logic                rst_ni,
  i2crm_cmd_if.sink           cmd_i,
  i2crm_res_if.source         res_o,
  i2crm_cfg_if.sink           cfg_i
);

  i2crm_pkg::state_t st_q, st_d;
  i2crm_pkg::res_t   res_q, res_d;
  logic              res_valid_q;
  logic [7:0]        phase_ticks_q;
  logic [7:0]        limit;
  logic              in_acc;
  logic              ent;
  i2crm_pkg::phase_e ent_ph;
  logic              done;
  logic              repeated;
  logic              s;

  assign cfg_i.ready = 1'b1;
  assign cmd_i.ready = !res_valid_q || res_o.ready;
  assign in_acc      = cmd_i.valid && cmd_i.ready;
  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  assign limit    = (phase_ticks_q == 8'd0) ? 8'd1 : phase_ticks_q;
  assign repeated = st_q.read_mode && (st_q.stage == i2crm_pkg::STAGE_LAST);
  assign s        = cmd_i.data.sda_in;

  always_comb begin
    st_d   = st_q;
    res_d  = '0;
    ent    = 1'b0;
    ent_ph = i2crm_pkg::PH_IDLE;
    done   = 1'b0;

    if (st_q.phase == i2crm_pkg::PH_IDLE) begin
      if (cmd_i.data.command == i2crm_pkg::CMD_WRITE ||
          cmd_i.data.command == i2crm_pkg::CMD_READ) begin
        st_d.held_device   = cmd_i.data.device_address;
        st_d.held_register = cmd_i.data.register_address;
        st_d.held_data     = cmd_i.data.write_data;
        st_d.read_mode     = (cmd_i.data.command == i2crm_pkg::CMD_READ);
        st_d.bytes_left    = cmd_i.data.read_count;
        st_d.stage         = i2crm_pkg::STAGE_DEV;
        st_d.pending       = i2crm_pkg::STS_OK;
        st_d.bit_cnt       = '0;
        if (st_d.read_mode && cmd_i.data.read_count == 8'd0) begin
          done            = 1'b1;
          res_d.status    = i2crm_pkg::STS_ZERO_CNT;
        end else begin
          ent    = 1'b1;
          ent_ph = i2crm_pkg::PH_ST0;
        end
      end
    end else begin
      st_d.tick = st_q.tick + 8'd1;
      if (st_d.tick >= limit) begin
        st_d.tick = '0;
        ent = 1'b1;
        unique case (st_q.phase)
          i2crm_pkg::PH_ST0: begin
            if (!s) begin
              if (repeated) begin
                st_d.shift   = st_q.held_device + 8'd1;
                st_d.bit_cnt = '0;
                ent_ph       = i2crm_pkg::PH_TX0;
              end else begin
                ent          = 1'b0;
                st_d.pending = i2crm_pkg::STS_SDA_LOW;
                st_d.phase   = i2crm_pkg::PH_IDLE;
                done         = 1'b1;
              end
            end else begin
              ent_ph = i2crm_pkg::PH_ST1;
            end
          end
          i2crm_pkg::PH_ST1: begin
            if (s) begin
              if (repeated) begin
                st_d.shift   = st_q.held_device + 8'd1;
                st_d.bit_cnt = '0;
                ent_ph       = i2crm_pkg::PH_TX0;
              end else begin
                ent          = 1'b0;
                st_d.pending = i2crm_pkg::STS_SDA_HIGH;
                st_d.phase   = i2crm_pkg::PH_IDLE;
                done         = 1'b1;
              end
            end else begin
              ent_ph = i2crm_pkg::PH_ST2;
            end
          end
          i2crm_pkg::PH_ST2: begin
            st_d.shift   = repeated ? st_q.held_device + 8'd1 : st_q.held_device;
            st_d.bit_cnt = '0;
            ent_ph       = i2crm_pkg::PH_TX0;
          end
          i2crm_pkg::PH_TX0: ent_ph = i2crm_pkg::PH_TX1;
          i2crm_pkg::PH_TX1: ent_ph = i2crm_pkg::PH_TX2;
          i2crm_pkg::PH_TX2: begin
            st_d.shift   = {st_q.shift[6:0], 1'b0};
            st_d.bit_cnt = st_q.bit_cnt + 4'd1;
            ent_ph       = (st_d.bit_cnt >= i2crm_pkg::BITS_PER_BYTE) ?
                           i2crm_pkg::PH_WA0 : i2crm_pkg::PH_TX0;
          end
          i2crm_pkg::PH_WA0: ent_ph = i2crm_pkg::PH_WA1;
          i2crm_pkg::PH_WA1: ent_ph = i2crm_pkg::PH_WA2;
          i2crm_pkg::PH_WA2: begin
            st_d.bit_cnt = {3'd0, s};
            ent_ph       = i2crm_pkg::PH_WA3;
          end
          i2crm_pkg::PH_WA3: begin
            if (st_q.stage == i2crm_pkg::STAGE_DEV) begin
              if (st_q.bit_cnt != 4'd0) begin
                st_d.pending = i2crm_pkg::STS_NO_ACK;
                ent_ph       = i2crm_pkg::PH_SP0;
              end else begin
                st_d.stage   = i2crm_pkg::STAGE_REG;
                st_d.shift   = st_q.held_register;
                st_d.bit_cnt = '0;
                ent_ph       = i2crm_pkg::PH_TX0;
              end
            end else if (st_q.stage == i2crm_pkg::STAGE_REG) begin
              st_d.stage = i2crm_pkg::STAGE_LAST;
              if (st_q.read_mode) begin
                ent_ph = i2crm_pkg::PH_ST0;
              end else begin
                st_d.shift   = st_q.held_data;
                st_d.bit_cnt = '0;
                ent_ph       = i2crm_pkg::PH_TX0;
              end
            end else if (st_q.read_mode) begin
              st_d.shift   = '0;
              st_d.bit_cnt = '0;
              ent_ph       = i2crm_pkg::PH_RX0;
            end else begin
              ent_ph = i2crm_pkg::PH_SP0;
            end
          end
          i2crm_pkg::PH_RX0: ent_ph = i2crm_pkg::PH_RX1;
          i2crm_pkg::PH_RX1: begin
            st_d.shift   = {st_q.shift[6:0], s};
            st_d.bit_cnt = st_q.bit_cnt + 4'd1;
            if (st_d.bit_cnt >= i2crm_pkg::BITS_PER_BYTE) begin
              res_d.read_byte  = st_d.shift;
              res_d.byte_valid = 1'b1;
              res_d.last_byte  = (st_q.bytes_left <= 8'd1);
              ent_ph           = i2crm_pkg::PH_AK0;
            end else begin
              ent_ph = i2crm_pkg::PH_RX0;
            end
          end
          i2crm_pkg::PH_AK0: ent_ph = i2crm_pkg::PH_AK1;
          i2crm_pkg::PH_AK1: ent_ph = i2crm_pkg::PH_AK2;
          i2crm_pkg::PH_AK2: ent_ph = i2crm_pkg::PH_AK3;
          i2crm_pkg::PH_AK3: begin
            if (st_q.bytes_left != 8'd0) begin
              st_d.bytes_left = st_q.bytes_left - 8'd1;
            end
            if (st_d.bytes_left != 8'd0) begin
              st_d.shift   = '0;
              st_d.bit_cnt = '0;
              ent_ph       = i2crm_pkg::PH_RX0;
            end else begin
              ent_ph = i2crm_pkg::PH_SP0;
            end
          end
          i2crm_pkg::PH_SP0: ent_ph = i2crm_pkg::PH_SP1;
          i2crm_pkg::PH_SP1: ent_ph = i2crm_pkg::PH_SP2;
          i2crm_pkg::PH_SP2: ent_ph = i2crm_pkg::PH_SP3;
          i2crm_pkg::PH_SP3: begin
            ent        = 1'b0;
            st_d.phase = i2crm_pkg::PH_IDLE;
            done       = 1'b1;
          end
          default: begin
            ent        = 1'b0;
            st_d.phase = i2crm_pkg::PH_IDLE;
          end
        endcase
        if (done) begin
          res_d.status = st_d.pending;
        end
      end
    end

    // line drives of the phase being entered
    if (ent) begin
      st_d.phase = ent_ph;
      st_d.tick  = '0;
      unique case (ent_ph)
        i2crm_pkg::PH_ST0: begin
          st_d.sda = 1'b1;
          st_d.scl = 1'b1;
        end
        i2crm_pkg::PH_ST1, i2crm_pkg::PH_ST2, i2crm_pkg::PH_SP1: st_d.sda = 1'b0;
        i2crm_pkg::PH_TX0, i2crm_pkg::PH_WA0, i2crm_pkg::PH_WA3,
        i2crm_pkg::PH_AK0, i2crm_pkg::PH_AK3, i2crm_pkg::PH_SP0: st_d.scl = 1'b0;
        i2crm_pkg::PH_TX1: st_d.sda = st_d.shift[7];
        i2crm_pkg::PH_TX2, i2crm_pkg::PH_WA2, i2crm_pkg::PH_RX1,
        i2crm_pkg::PH_AK2, i2crm_pkg::PH_SP2: st_d.scl = 1'b1;
        i2crm_pkg::PH_WA1, i2crm_pkg::PH_SP3: st_d.sda = 1'b1;
        i2crm_pkg::PH_RX0: begin
          st_d.scl = 1'b0;
          st_d.sda = 1'b1;
        end
        i2crm_pkg::PH_AK1: st_d.sda = (st_d.bytes_left > 8'd1) ? 1'b0 : 1'b1;
        default: ;
      endcase
    end

    res_d.scl_out  = st_d.scl;
    res_d.sda_out  = st_d.sda;
    res_d.busy_res = (st_d.phase != i2crm_pkg::PH_IDLE);
    res_d.done_res = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= '{phase: i2crm_pkg::PH_IDLE, scl: 1'b1, sda: 1'b1, default: '0};
      res_valid_q   <= 1'b0;
      phase_ticks_q <= i2crm_pkg::PHASE_TICKS_RST;
    end else begin
      if (in_acc) begin
        st_q <= st_d;
      end
      if (in_acc) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        phase_ticks_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

endmodule

[design/i2crm_checker.sv]
`timescale 1ns / 1ps

module i2crm_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            cmd_valid_i,
  input logic            cmd_ready_i,
  input logic            res_valid_i,
  input logic            res_ready_i,
  input i2crm_pkg::res_t res_data_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_data_i))
    else $error("stalled result changed");

  // every command transfer yields a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> res_valid_i)
    else $error("command transfer without result");

  // a finished transaction leaves the block idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_data_i.done_res |-> !res_data_i.busy_res &&
      !res_data_i.byte_valid)
    else $error("done while busy");

  // status only reported with done, and a received byte only mid-transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (!res_data_i.done_res || res_data_i.byte_valid) |->
      res_data_i.status == i2crm_pkg::STS_OK &&
      (!res_data_i.byte_valid || res_data_i.busy_res))
    else $error("stray status or byte");

endmodule

bind i2c_register_master i2crm_checker u_i2crm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cmd_valid_i (cmd_i.valid),
  .cmd_ready_i (cmd_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.data)
);
